### rtl/isort_pkg.sv
// ----------------------------------------------------------------------------
// isort_pkg
// Shared key width and type, and the command and status bundles between the
// sorter's controller and its datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package isort_pkg;

  localparam int unsigned KEY_W = 32;

  typedef logic signed [KEY_W-1:0] key_t;

  typedef struct packed {
    logic capture;
    logic rd_prev;
    logic shift;
    logic place;
    logic load_out;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic pos_zero;
    logic greater;
    logic last;
    logic is_final;
  } sts_t;

endpackage

`default_nettype wire

### rtl/isort_datapath.sv
// ----------------------------------------------------------------------------
// isort_datapath
// Key store memory, fill count, position pointer and result registers. Keys
// are shifted up one entry per command until the new key's slot is found.
// ----------------------------------------------------------------------------
`default_nettype none

module isort_datapath #(
  parameter int unsigned MAX_KEYS = 64
) (
  input  wire                  logic clk_i,
  input  wire                  logic rst_ni,
  input  wire isort_pkg::cmd_t cmd_i,
  output isort_pkg::sts_t      sts_o,
  input  wire isort_pkg::key_t key_value_i,
  input  wire                  logic last_key_i,
  output isort_pkg::key_t      sorted_value_o,
  output logic                 final_result_o,
  output logic                 overflow_o
);

  import isort_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_KEYS);
  localparam int unsigned CNT_W = $clog2(MAX_KEYS + 1);
  localparam logic [CNT_W-1:0] CntMax = CNT_W'(MAX_KEYS);
  localparam logic [CNT_W-1:0] CntOne = CNT_W'(1);

  key_t             mem_q [MAX_KEYS];
  key_t             rd_q;
  key_t             key_q;
  logic             last_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic             drop_q, drop_d;
  key_t             out_value_q;
  logic             out_final_q;
  logic             out_ovf_q;
  logic [CNT_W-1:0] pos_prev;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  key_t             wr_data;
  logic             wr_en;
  logic             full;

  assign full     = (count_q == CntMax);
  assign pos_prev = pos_q - CntOne;
  assign rd_addr  = cmd_i.rd_prev ? pos_prev[IDX_W-1:0] : pos_q[IDX_W-1:0];
  assign wr_addr  = pos_q[IDX_W-1:0];
  assign wr_en    = cmd_i.shift | cmd_i.place;
  assign wr_data  = cmd_i.shift ? rd_q : key_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[rd_addr];
  end

  always_comb begin
    count_d = count_q;
    pos_d   = pos_q;
    drop_d  = drop_q;
    if (cmd_i.capture) begin
      pos_d = full ? '0 : count_q;
      if (full) begin
        drop_d = 1'b1;
      end
    end
    if (cmd_i.shift) begin
      pos_d = pos_prev;
    end
    if (cmd_i.place) begin
      count_d = count_q + CntOne;
      pos_d   = '0;
    end
    if (cmd_i.load_out) begin
      pos_d = pos_q + CntOne;
    end
    if (cmd_i.clear) begin
      count_d = '0;
      drop_d  = 1'b0;
      pos_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pos_q   <= '0;
      drop_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      pos_q   <= pos_d;
      drop_q  <= drop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      key_q  <= key_value_i;
      last_q <= last_key_i;
    end
    if (cmd_i.load_out) begin
      out_value_q <= rd_q;
      out_final_q <= ((pos_q + CntOne) == count_q);
      out_ovf_q   <= drop_q;
    end
  end

  assign sts_o.full     = full;
  assign sts_o.pos_zero = (pos_q == '0);
  assign sts_o.greater  = (rd_q > key_q);
  assign sts_o.last     = last_q;
  assign sts_o.is_final = out_final_q;

  assign sorted_value_o = out_value_q;
  assign final_result_o = out_final_q;
  assign overflow_o     = out_ovf_q;

endmodule

`default_nettype wire

### rtl/isort_ctrl.sv
// ----------------------------------------------------------------------------
// isort_ctrl
// State machine that sequences key insertion and the readout of a sorted set,
// and owns both channel handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module isort_ctrl (
  input  wire                  logic clk_i,
  input  wire                  logic rst_ni,
  input  wire                  logic in_valid_i,
  output logic                 in_stall_o,
  input  wire                  logic last_key_i,
  output logic                 out_valid_o,
  input  wire                  logic out_stall_i,
  output isort_pkg::cmd_t      cmd_o,
  input  wire isort_pkg::sts_t sts_i
);

  import isort_pkg::*;

  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StSeek    = 3'd1;
  localparam logic [2:0] StCmp     = 3'd2;
  localparam logic [2:0] StEmitRd  = 3'd3;
  localparam logic [2:0] StEmitLd  = 3'd4;
  localparam logic [2:0] StEmitOut = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (sts_i.full) begin
            state_d = last_key_i ? StEmitRd : StIdle;
          end else begin
            state_d = StSeek;
          end
        end
      end
      StSeek: begin
        if (sts_i.pos_zero) begin
          cmd_o.place = 1'b1;
          state_d     = sts_i.last ? StEmitRd : StIdle;
        end else begin
          cmd_o.rd_prev = 1'b1;
          state_d       = StCmp;
        end
      end
      StCmp: begin
        if (sts_i.greater) begin
          cmd_o.shift = 1'b1;
          state_d     = StSeek;
        end else begin
          cmd_o.place = 1'b1;
          state_d     = sts_i.last ? StEmitRd : StIdle;
        end
      end
      StEmitRd: begin
        state_d = StEmitLd;
      end
      StEmitLd: begin
        cmd_o.load_out = 1'b1;
        out_valid_d    = 1'b1;
        state_d        = StEmitOut;
      end
      StEmitOut: begin
        if (!out_stall_i) begin
          out_valid_d = 1'b0;
          if (sts_i.is_final) begin
            cmd_o.clear = 1'b1;
            state_d     = StIdle;
          end else begin
            state_d = StEmitRd;
          end
        end
      end
      default: begin
        state_d     = StIdle;
        out_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

### rtl/insertion_sorter.sv
// ----------------------------------------------------------------------------
// insertion_sorter
// Stable insertion sorter for signed 32-bit keys, emitting each set in
// ascending order.
// ----------------------------------------------------------------------------
// A set of keys is pushed in one request at a time, the final key of the set
// flagged by last_key_i. Each key is inserted into a single-port-write,
// registered-read memory by walking down from the top of the store: every
// stored key greater than the new one is read and shifted up one entry, and
// the walk stops at the bottom of the store or at the first smaller or equal
// key, and the new key is placed in the freed slot. Keys that arrive when
// MAX_KEYS keys are already held are dropped, and every result of that set
// carries overflow_o. After the last key the set is read back, each result
// being read, loaded and then held while out_stall_i is high before the next
// is read, the largest key carrying final_result_o, and the store is then
// empty for the next set. No input is taken during readout.
// ----------------------------------------------------------------------------
`default_nettype none

module insertion_sorter #(
  parameter int unsigned MAX_KEYS = 64
) (
  input  wire                  logic clk_i,
  input  wire                  logic rst_ni,
  input  wire                  logic in_valid_i,
  output logic                 in_stall_o,
  input  wire isort_pkg::key_t key_value_i,
  input  wire                  logic last_key_i,
  output logic                 out_valid_o,
  input  wire                  logic out_stall_i,
  output isort_pkg::key_t      sorted_value_o,
  output logic                 final_result_o,
  output logic                 overflow_o
);

  import isort_pkg::*;

  cmd_t cmd;
  sts_t sts;

  isort_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .last_key_i (last_key_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  isort_datapath #(
    .MAX_KEYS(MAX_KEYS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .key_value_i   (key_value_i),
    .last_key_i    (last_key_i),
    .sorted_value_o(sorted_value_o),
    .final_result_o(final_result_o),
    .overflow_o    (overflow_o)
  );

endmodule

`default_nettype wire

### rtl/isort_checker.sv
// ----------------------------------------------------------------------------
// isort_checker
// Port-level checks on the sorter's request flow, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module isort_checker (
  input wire                  logic clk_i,
  input wire                  logic rst_ni,
  input wire                  logic in_valid_i,
  input wire                  logic in_stall_o,
  input wire isort_pkg::key_t key_value_i,
  input wire                  logic last_key_i,
  input wire                  logic out_valid_o,
  input wire                  logic out_stall_i,
  input wire isort_pkg::key_t sorted_value_o,
  input wire                  logic final_result_o,
  input wire                  logic overflow_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sorted_value_o)
      && $stable(final_result_o) && $stable(overflow_o))
    else $error("Stalled result request changed.");

  a_no_input_during_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("Input accepted while a result is pending.");

  a_key_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !out_valid_o)
    else $error("Result appeared right after an input request.");

  a_final_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && final_result_o |=> !out_valid_o && !in_stall_o)
    else $error("Run did not end after the final result.");

endmodule

bind insertion_sorter isort_checker u_isort_checker (.*);

`default_nettype wire
